// ===== hw/rtl/rpmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rpmc_pkg;

  // Gear selector codes
  localparam logic [7:0] GEAR_REVERSE = 8'h0E;
  localparam logic [7:0] GEAR_PARK    = 8'h0D;
  localparam logic [7:0] GEAR_NEUTRAL = 8'h00;

  // Turn indicator codes
  localparam logic [7:0] TURN_LEFT  = 8'h02;
  localparam logic [7:0] TURN_RIGHT = 8'h01;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_ENABLE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARK_POSITIONS      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATIVE_POSITIONS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL_MS    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELAY_MS       = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTORE_HOLD_MS     = 8'd5;

  // Configuration reset values
  localparam logic [31:0] SEND_INTERVAL_RST = 32'd900;
  localparam logic [31:0] EXIT_DELAY_RST    = 32'd10000;
  localparam logic [31:0] RESTORE_HOLD_RST  = 32'd15000;

  // Mirror state kept between checks
  typedef struct packed {
    logic        left_park;
    logic        right_park;
    logic        restore;
    logic        store;
    logic [31:0] drive_entry;
    logic [31:0] restore_start;
    logic [31:0] last_send;
  } mirror_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/reverse_park_mirror_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Reverse park mirror controller. Each input transaction is one periodic check
// (time, gear, turn indicator, position-stored flag) and yields exactly one
// result transaction with the mirror frame, its send flag and the mirror status.
// The block is a two-register pipeline: an input register feeds a single pass
// of compare-and-update logic whose outcome lands in the result register, so a
// new check is taken every cycle unless out_ready stalls the result register;
// its result passes through the input and then the result register. Throughput
// is one check per cycle without such a stall, set by the single state update
// per check; the input register lets a check enter while a previous result
// still waits for out_ready. Configuration writes are taken every cycle on the
// cfg_ channel and should be issued only while no check is in flight.
module reverse_park_mirror_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [rpmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_now_ms,
  input  wire logic [7:0]  in_gear_code,
  input  wire logic [7:0]  in_turn_code,
  input  wire logic        in_position_stored,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_send_frame,
  output logic [31:0]      out_frame_bytes,
  output logic             out_store_request,
  output logic             out_left_lowered,
  output logic             out_right_lowered,
  output logic             out_restoring
);

  // configuration registers
  logic        feature_enable_r;
  logic [31:0] park_positions_r;
  logic [31:0] operative_positions_r;
  logic [31:0] send_interval_r;
  logic [31:0] exit_delay_r;
  logic [31:0] restore_hold_r;

  // input register
  logic        s1_valid_r;
  logic [31:0] s1_now_r;
  logic [7:0]  s1_gear_r;
  logic [7:0]  s1_turn_r;
  logic        s1_stored_r;

  // mirror state
  rpmc_pkg::mirror_state_t st_r;
  rpmc_pkg::mirror_state_t st_nxt;

  // result register
  logic        out_valid_r;
  logic        send_r;
  logic [31:0] frame_r;
  logic        send_nxt;
  logic [31:0] frame_nxt;

  logic adv;
  logic in_acc;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign in_acc    = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_enable_r      <= 1'b0;
      park_positions_r      <= '0;
      operative_positions_r <= '0;
      send_interval_r       <= rpmc_pkg::SEND_INTERVAL_RST;
      exit_delay_r          <= rpmc_pkg::EXIT_DELAY_RST;
      restore_hold_r        <= rpmc_pkg::RESTORE_HOLD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rpmc_pkg::CFG_FEATURE_ENABLE:      feature_enable_r      <= cfg_wdata[0];
        rpmc_pkg::CFG_PARK_POSITIONS:      park_positions_r      <= cfg_wdata;
        rpmc_pkg::CFG_OPERATIVE_POSITIONS: operative_positions_r <= cfg_wdata;
        rpmc_pkg::CFG_SEND_INTERVAL_MS:    send_interval_r       <= cfg_wdata;
        rpmc_pkg::CFG_EXIT_DELAY_MS:       exit_delay_r          <= cfg_wdata;
        rpmc_pkg::CFG_RESTORE_HOLD_MS:     restore_hold_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r    <= in_now_ms;
      s1_gear_r   <= in_gear_code;
      s1_turn_r   <= in_turn_code;
      s1_stored_r <= in_position_stored;
    end
  end

  // Step logic: all elapsed-time compares run in parallel off the old state
  logic        is_rev;
  logic        is_stop;
  logic        is_turn;
  logic        any_park;
  logic        drive_expired;
  logic        restart;
  logic        send_due;
  logic        hold_done;
  logic [31:0] drive_elapsed;
  logic [31:0] send_elapsed;
  logic [31:0] hold_elapsed;

  always_comb begin
    is_rev   = (s1_gear_r == rpmc_pkg::GEAR_REVERSE);
    is_stop  = (s1_gear_r == rpmc_pkg::GEAR_PARK) || (s1_gear_r == rpmc_pkg::GEAR_NEUTRAL);
    is_turn  = (s1_turn_r == rpmc_pkg::TURN_LEFT) || (s1_turn_r == rpmc_pkg::TURN_RIGHT);
    any_park = st_r.left_park || st_r.right_park;

    drive_elapsed = s1_now_r - st_r.drive_entry;
    send_elapsed  = s1_now_r - st_r.last_send;
    hold_elapsed  = s1_now_r - st_r.restore_start;

    // a freshly captured entry time has zero elapsed and never expires
    drive_expired = (st_r.drive_entry != '0) && (drive_elapsed > exit_delay_r);
    send_due      = send_elapsed > send_interval_r;
    hold_done     = hold_elapsed > restore_hold_r;

    st_nxt    = st_r;
    send_nxt  = 1'b0;
    frame_nxt = '0;
    restart   = 1'b0;

    if (s1_stored_r) begin
      st_nxt.store = 1'b0;
    end

    if (feature_enable_r) begin
      // gear handling
      priority if (is_rev) begin
        st_nxt.drive_entry = '0;
        if (!st_r.restore && is_turn) begin
          if (!any_park) begin
            st_nxt.store = 1'b1;
          end
          if (s1_turn_r == rpmc_pkg::TURN_LEFT) begin
            st_nxt.left_park = 1'b1;
          end else begin
            st_nxt.right_park = 1'b1;
          end
        end
      end else if (is_stop) begin
        st_nxt.drive_entry = '0;
        restart            = any_park;
        st_nxt.left_park   = 1'b0;
        st_nxt.right_park  = 1'b0;
      end else begin
        if (any_park && (st_r.drive_entry == '0)) begin
          st_nxt.drive_entry = s1_now_r;
        end
        if (drive_expired) begin
          restart            = any_park;
          st_nxt.left_park   = 1'b0;
          st_nxt.right_park  = 1'b0;
          st_nxt.drive_entry = '0;
        end
      end

      if (restart) begin
        st_nxt.restore       = 1'b1;
        st_nxt.restore_start = s1_now_r;
      end

      // assemble the frame from the updated park flags
      frame_nxt[15:0]  = st_nxt.left_park  ? park_positions_r[15:0]
                                           : operative_positions_r[15:0];
      frame_nxt[31:16] = st_nxt.right_park ? park_positions_r[31:16]
                                           : operative_positions_r[31:16];

      // pace frames and time out the restore phase
      if (st_nxt.left_park || st_nxt.right_park || st_nxt.restore) begin
        if (!st_nxt.store && send_due) begin
          send_nxt         = 1'b1;
          st_nxt.last_send = s1_now_r;
        end
        if (st_nxt.restore && !restart && hold_done) begin
          st_nxt.restore = 1'b0;
        end
      end
    end
  end

  // Commit state on each step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      send_r  <= send_nxt;
      frame_r <= frame_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_send_frame    = send_r;
  assign out_frame_bytes   = frame_r;
  assign out_store_request = st_r.store;
  assign out_left_lowered  = st_r.left_park;
  assign out_right_lowered = st_r.right_park;
  assign out_restoring     = st_r.restore;

  // A sent frame never goes out while a store request is pending
  a_send_not_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && send_r |-> !st_r.store)
    else $error("frame sent with store request pending");

  // Restoring and lowered mirrors never coexist
  a_restore_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.restore && (st_r.left_park || st_r.right_park)))
    else $error("restore active with mirror lowered");

  // An armed drive timer implies a lowered mirror
  a_timer_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.drive_entry != '0) |-> (st_r.left_park || st_r.right_park))
    else $error("drive timer armed with no mirror lowered");

  // A sent frame records its time as the last send time
  a_last_send: assert property (@(posedge clk) disable iff (!rst_n)
    adv && send_nxt |=> st_r.last_send == $past(s1_now_r))
    else $error("last send time not updated");

endmodule
`default_nettype wire

// ===== verif/reverse_park_mirror_controller_test.sv =====
`timescale 1ns / 1ps

// One mirror result transaction, packed in port order
typedef struct packed {
  logic        send;
  logic [31:0] frame;
  logic        store;
  logic        left;
  logic        right;
  logic        restore;
} mirror_frame_t;

class mirror_tracker;
  // register copy
  logic        enable;
  logic [31:0] park_pos;
  logic [31:0] oper_pos;
  logic [31:0] pace_ms;
  logic [31:0] exit_delay_ms;
  logic [31:0] hold_ms;
  // controller state
  logic        left_down;
  logic        right_down;
  logic        restore_on;
  logic        store_req;
  logic [31:0] drive_t0;
  logic [31:0] restore_t0;
  logic [31:0] last_sent_t;
  mirror_frame_t pending_frames[$];
  int          mismatches;

  function new();
    enable        = 1'b0;
    park_pos      = '0;
    oper_pos      = '0;
    pace_ms       = rpmc_pkg::SEND_INTERVAL_RST;
    exit_delay_ms = rpmc_pkg::EXIT_DELAY_RST;
    hold_ms       = rpmc_pkg::RESTORE_HOLD_RST;
    left_down     = 1'b0;
    right_down    = 1'b0;
    restore_on    = 1'b0;
    store_req     = 1'b0;
    drive_t0      = '0;
    restore_t0    = '0;
    last_sent_t   = '0;
    mismatches    = 0;
  endfunction

  function void write_reg(logic [rpmc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      rpmc_pkg::CFG_FEATURE_ENABLE:      enable = data[0];
      rpmc_pkg::CFG_PARK_POSITIONS:      park_pos = data;
      rpmc_pkg::CFG_OPERATIVE_POSITIONS: oper_pos = data;
      rpmc_pkg::CFG_SEND_INTERVAL_MS:    pace_ms = data;
      rpmc_pkg::CFG_EXIT_DELAY_MS:       exit_delay_ms = data;
      rpmc_pkg::CFG_RESTORE_HOLD_MS:     hold_ms = data;
      default: ;
    endcase
  endfunction

  // Only a lowered mirror opens a restoring phase
  function void start_restore(logic [31:0] now);
    if (left_down || right_down) begin
      restore_on = 1'b1;
      restore_t0 = now;
    end
    left_down  = 1'b0;
    right_down = 1'b0;
  endfunction

  // Advance the controller by one accepted check and queue its frame
  function void note_check(logic [31:0] now, logic [7:0] gear, logic [7:0] turn,
                           logic stored);
    mirror_frame_t want;
    logic [31:0]   since_drive;
    logic [31:0]   since_send;
    logic [31:0]   since_restore;
    want = '0;
    if (stored) store_req = 1'b0;
    if (enable) begin
      if (gear == rpmc_pkg::GEAR_REVERSE) begin
        drive_t0 = '0;
        if (!restore_on && (turn == rpmc_pkg::TURN_LEFT || turn == rpmc_pkg::TURN_RIGHT)) begin
          if (!left_down && !right_down) store_req = 1'b1;
          if (turn == rpmc_pkg::TURN_LEFT) left_down = 1'b1;
          else right_down = 1'b1;
        end
      end else if (gear == rpmc_pkg::GEAR_PARK || gear == rpmc_pkg::GEAR_NEUTRAL) begin
        drive_t0 = '0;
        start_restore(now);
      end else begin
        // a capture at time zero leaves the timer unarmed
        if ((left_down || right_down) && drive_t0 == '0) drive_t0 = now;
        since_drive = now - drive_t0;
        if (drive_t0 != '0 && since_drive > exit_delay_ms) begin
          start_restore(now);
          drive_t0 = '0;
        end
      end

      want.frame = oper_pos;
      if (left_down) want.frame[15:0] = park_pos[15:0];
      if (right_down) want.frame[31:16] = park_pos[31:16];

      if (left_down || right_down || restore_on) begin
        since_send = now - last_sent_t;
        if (!store_req && since_send > pace_ms) begin
          want.send   = 1'b1;
          last_sent_t = now;
        end
        since_restore = now - restore_t0;
        if (restore_on && since_restore > hold_ms) restore_on = 1'b0;
      end
    end
    want.store   = store_req;
    want.left    = left_down;
    want.right   = right_down;
    want.restore = restore_on;
    pending_frames.push_back(want);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Compare one result transaction with the oldest queued frame
  function void check_frame(mirror_frame_t got);
    mirror_frame_t want;
    if (pending_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result with nothing pending: frame %h send %b", got.frame, got.send);
      return;
    end
    want = pending_frames.pop_front();
    compare_field("send_frame", want.send, got.send);
    compare_field("frame_bytes", want.frame, got.frame);
    compare_field("store_request", want.store, got.store);
    compare_field("left_lowered", want.left, got.left);
    compare_field("right_lowered", want.right, got.right);
    compare_field("restoring", want.restore, got.restore);
  endfunction

  function int pending();
    return pending_frames.size();
  endfunction
endclass

module reverse_park_mirror_controller_test;

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int PHASES          = 8;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rpmc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                    cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [31:0]                    in_now_ms;
  logic [7:0]                     in_gear_code;
  logic [7:0]                     in_turn_code;
  logic                           in_position_stored;
  logic                           out_valid;
  logic                           out_ready;
  logic                           out_send_frame;
  logic [31:0]                    out_frame_bytes;
  logic                           out_store_request;
  logic                           out_left_lowered;
  logic                           out_right_lowered;
  logic                           out_restoring;

  mirror_tracker tracker;
  logic          full_rate = 1'b0;
  logic          hold_off_req = 1'b0;
  int unsigned   checks_sent = 0;
  int unsigned   cycle_count;
  int unsigned   hold_cycles;
  logic [31:0]   clock_ms;
  int unsigned   tstep;

  reverse_park_mirror_controller uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_now_ms         (in_now_ms),
    .in_gear_code      (in_gear_code),
    .in_turn_code      (in_turn_code),
    .in_position_stored(in_position_stored),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_send_frame    (out_send_frame),
    .out_frame_bytes   (out_frame_bytes),
    .out_store_request (out_store_request),
    .out_left_lowered  (out_left_lowered),
    .out_right_lowered (out_right_lowered),
    .out_restoring     (out_restoring)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] next_ms();
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, tstep);
    return clock_ms;
  endfunction

  function automatic logic [7:0] pick_turn();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return rpmc_pkg::TURN_LEFT;
    else if (r < 80) return rpmc_pkg::TURN_RIGHT;
    else return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_drive_gear();
    logic [7:0] g;
    g = 8'($urandom);
    while (g == rpmc_pkg::GEAR_REVERSE || g == rpmc_pkg::GEAR_PARK ||
           g == rpmc_pkg::GEAR_NEUTRAL) g = 8'($urandom);
    return g;
  endfunction

  function automatic logic [7:0] pick_any_gear();
    case ($urandom_range(0, 3))
      0: return rpmc_pkg::GEAR_REVERSE;
      1: return rpmc_pkg::GEAR_PARK;
      2: return rpmc_pkg::GEAR_NEUTRAL;
      default: return pick_drive_gear();
    endcase
  endfunction

  // Watch every handshake; values seen here are the ones the block sampled
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready)
        tracker.note_check(in_now_ms, in_gear_code, in_turn_code, in_position_stored);
      if (out_valid && out_ready)
        tracker.check_frame({out_send_frame, out_frame_bytes, out_store_request,
                             out_left_lowered, out_right_lowered, out_restoring});
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned run;
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          hold_cycles++;
        end
      end
      out_ready <= 1'b1;
      run = full_rate ? 30 : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      stall = full_rate ? 0 : pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Offer one check transaction and hold it until accepted
  task automatic drive_check(logic [31:0] now, logic [7:0] gear, logic [7:0] turn,
                             logic stored);
    int unsigned gap;
    gap = full_rate ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_now_ms          <= now;
    in_gear_code       <= gear;
    in_turn_code       <= turn;
    in_position_stored <= stored;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    checks_sent++;
  endtask

  task automatic write_cfg(logic [rpmc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drain the block, then rewrite every register
  task automatic load_setting(logic en, logic [31:0] park, logic [31:0] oper,
                              logic [31:0] pace, logic [31:0] exit_d, logic [31:0] hold);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_cfg(rpmc_pkg::CFG_FEATURE_ENABLE, {31'd0, en});
    write_cfg(rpmc_pkg::CFG_PARK_POSITIONS, park);
    write_cfg(rpmc_pkg::CFG_OPERATIVE_POSITIONS, oper);
    write_cfg(rpmc_pkg::CFG_SEND_INTERVAL_MS, pace);
    write_cfg(rpmc_pkg::CFG_EXIT_DELAY_MS, exit_d);
    write_cfg(rpmc_pkg::CFG_RESTORE_HOLD_MS, hold);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Reverse with indicators, leave reverse, then wander while restoring
  task automatic run_maneuver();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n)
      drive_check(next_ms(), rpmc_pkg::GEAR_REVERSE, pick_turn(), $urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 1) begin
      n = $urandom_range(2, 12);
      repeat (n)
        drive_check(next_ms(), pick_drive_gear(), 8'($urandom), $urandom_range(0, 4) == 0);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n)
        drive_check(next_ms(),
                    ($urandom_range(0, 1) == 1) ? rpmc_pkg::GEAR_PARK : rpmc_pkg::GEAR_NEUTRAL,
                    8'($urandom), $urandom_range(0, 4) == 0);
    end
    n = $urandom_range(2, 10);
    repeat (n) drive_check(next_ms(), pick_any_gear(), pick_turn(), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int unsigned target;
    tracker            = new();
    rst_n              <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    in_valid           <= 1'b0;
    in_now_ms          <= '0;
    in_gear_code       <= '0;
    in_turn_code       <= '0;
    in_position_stored <= 1'b0;
    clock_ms = '0;
    tstep    = 10;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: function disabled
    drive_check(32'd0, rpmc_pkg::GEAR_REVERSE, rpmc_pkg::TURN_LEFT, 1'b0);

    load_setting(1'b1, 32'hA1B2_C3D4, 32'h1122_3344, 32'd0, 32'd5, 32'd8);
    // indicator that is neither arrow, then both mirrors with a pending store
    drive_check(32'd1, rpmc_pkg::GEAR_REVERSE, 8'h07, 1'b0);
    drive_check(32'd2, rpmc_pkg::GEAR_REVERSE, rpmc_pkg::TURN_LEFT, 1'b0);
    drive_check(32'd3, rpmc_pkg::GEAR_REVERSE, rpmc_pkg::TURN_RIGHT, 1'b0);
    drive_check(32'd4, rpmc_pkg::GEAR_REVERSE, 8'h00, 1'b1);
    // drive hysteresis runs out, then an indicator while restoring
    drive_check(32'd5, 8'h01, 8'h00, 1'b0);
    drive_check(32'd20, 8'hFF, rpmc_pkg::TURN_LEFT, 1'b0);
    drive_check(32'd21, rpmc_pkg::GEAR_REVERSE, rpmc_pkg::TURN_LEFT, 1'b0);
    drive_check(32'd40, rpmc_pkg::GEAR_PARK, 8'h00, 1'b0);
    // drive entry captured at time zero stays unarmed
    drive_check(32'd50, rpmc_pkg::GEAR_REVERSE, rpmc_pkg::TURN_RIGHT, 1'b0);
    drive_check(32'd0, 8'h03, 8'h00, 1'b1);
    drive_check(32'd3, 8'h03, 8'h00, 1'b0);
    drive_check(32'd60, 8'h03, 8'h00, 1'b0);
    drive_check(32'd61, rpmc_pkg::GEAR_NEUTRAL, rpmc_pkg::TURN_RIGHT, 1'b0);
    drive_check(32'hFFFF_FFFF, rpmc_pkg::GEAR_REVERSE, 8'hFF, 1'b1);
    drive_check(32'hFFFF_FFFF, rpmc_pkg::GEAR_REVERSE, rpmc_pkg::TURN_LEFT, 1'b0);
    // disabled with a store request still pending
    load_setting(1'b0, 32'hA1B2_C3D4, 32'h1122_3344, 32'd0, 32'd5, 32'd8);
    drive_check(32'd100, rpmc_pkg::GEAR_PARK, 8'h00, 1'b0);
    drive_check(32'd101, rpmc_pkg::GEAR_REVERSE, rpmc_pkg::TURN_RIGHT, 1'b1);
    drive_check(32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1);

    // Random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      full_rate = (p == 1);
      case (p)
        0: begin
          load_setting(1'b1, $urandom, $urandom, 32'd20, 32'd100, 32'd150);
          tstep = 40;
        end
        1: begin
          load_setting(1'b1, 32'hFFFF_FFFF, 32'h0, 32'd0, 32'd0, 32'd0);
          tstep = 3;
          hold_off_req = 1'b1;
        end
        2: begin
          load_setting(1'b1, $urandom, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          tstep = 32'h00FF_FFFF;
        end
        3: begin
          load_setting(1'b0, $urandom, $urandom, 32'd10, 32'd50, 32'd80);
          tstep = 50;
        end
        4: begin
          load_setting(1'b1, $urandom, $urandom, rpmc_pkg::SEND_INTERVAL_RST,
                       rpmc_pkg::EXIT_DELAY_RST, rpmc_pkg::RESTORE_HOLD_RST);
          tstep = 3000;
        end
        5: begin
          load_setting(1'b1, $urandom, $urandom, $urandom_range(0, 300),
                       $urandom_range(0, 600), $urandom_range(0, 900));
          tstep = 200;
          clock_ms = 32'hFFFF_F000;
        end
        6: begin
          load_setting(1'b1, 32'h0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
          tstep = 4;
        end
        default: begin
          load_setting(1'b1, $urandom, $urandom, $urandom_range(0, 100),
                       $urandom_range(0, 400), $urandom_range(0, 400));
          tstep = 150;
        end
      endcase
      target = checks_sent + ITEMS_PER_PHASE;
      while (checks_sent < target) begin
        if ($urandom_range(0, 99) < 80) run_maneuver();
        else drive_check(($urandom_range(0, 1) == 1) ? $urandom : next_ms(), 8'($urandom),
                         8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    full_rate = 1'b0;

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("reverse_park_mirror_controller verification clean");
    else
      $display("reverse_park_mirror_controller verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("reverse_park_mirror_controller verification failed");
    $finish;
  end

endmodule

// ===== reverse_park_mirror_controller.f =====
hw/rtl/rpmc_pkg.sv
hw/rtl/reverse_park_mirror_controller.sv
verif/reverse_park_mirror_controller_test.sv
